/* rtl/assert_macros.svh */
// Assertion macros used by counting_sort_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define CS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("counting sort check failed");

// Clocked check that also runs during reset.
`define CS_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("counting sort reset check failed");

`endif

/* rtl/cs_pkg.sv */
// Shared constants and types of the counting sort block.
package cs_pkg;

    localparam int IN_W           = 8;
    localparam int OUT_W          = 8;
    localparam int VALUE_BITS_DEF = 8;
    localparam int MAX_ITEMS_DEF  = 64;

    // One result request handed from the sequencer to the output register.
    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             last;
        logic             overflow;
    } t_res;

endpackage

/* rtl/counting_sort_core.sv */
// Counting sort: histogram load of a data set, then an ascending drain.
//
// Input channel: i_in_valid / o_in_stall with i_item_value, i_end_of_set.
//   An item is taken at a rising edge with i_in_valid high, o_in_stall low.
//   A counted item reads its bin, then writes it back incremented (S_LD);
//   an item beyond MAX_ITEMS is dropped without a bin write and flags overflow for the set.
// Output channel: o_out_valid / i_out_stall with o_sorted_value,
//   o_end_of_run, o_overflow. After the item marked i_end_of_set, bins are
//   walked from zero upward: each bin is read (S_RD), checked and cleared
//   (S_EVAL), and each of its results is handed out from S_EMIT.
//   The walk ends with the last counted value, flagged by o_end_of_run.
//   The first result follows the final item's bin write (S_LD, skipped when
//   it is dropped) and the reads of all empty bins below the smallest value.
// A one-entry output register holds each result; while the receiver
// stalls, the walk waits, and the next set may start loading as soon as
// the last result has entered that register.
// Reset (synchronous, active low) starts a clearing pass over all
// 2**VALUE_BITS histogram bins; o_in_stall stays high until it ends.
module counting_sort_core #(
    parameter int VALUE_BITS = cs_pkg::VALUE_BITS_DEF,
    parameter int MAX_ITEMS  = cs_pkg::MAX_ITEMS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [cs_pkg::IN_W-1:0]  i_item_value,
    input  logic                     i_end_of_set,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [cs_pkg::OUT_W-1:0] o_sorted_value,
    output logic                     o_end_of_run,
    output logic                     o_overflow
);

`include "assert_macros.svh"

    logic         w_busy;
    logic         w_push;
    logic         w_obuf_ready;
    cs_pkg::t_res w_res;
    cs_pkg::t_res w_out_res;

    cs_ctrl #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_ITEMS  (MAX_ITEMS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_item_value (i_item_value),
        .i_end_of_set (i_end_of_set),
        .o_busy       (w_busy),
        .i_obuf_ready (w_obuf_ready),
        .o_push       (w_push),
        .o_res        (w_res)
    );

    cs_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res),
        .o_ready (w_obuf_ready),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_res   (w_out_res)
    );

    assign o_in_stall     = w_busy;
    assign o_sorted_value = w_out_res.value;
    assign o_end_of_run   = w_out_res.last;
    assign o_overflow     = w_out_res.overflow;

    // a result never overwrites one the receiver has not taken
    `CS_ASSERT(a_push_room, i_clk, i_rst_n, w_push |-> w_obuf_ready)
    // once the final result is handed off the block is ready for a new set
    `CS_ASSERT(a_idle_after_run, i_clk, i_rst_n, (w_push && w_res.last) |=> !o_in_stall)
    // the clearing pass keeps the input stalled right after reset
    `CS_ASSERT_NR(a_clear_stall, i_clk, !i_rst_n |=> o_in_stall)

endmodule

/* rtl/cs_obuf.sv */
// Output register that holds one result request until the receiver takes it.
module cs_obuf (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  cs_pkg::t_res i_res,
    output logic         o_ready,
    input  logic         i_stall,
    output logic         o_valid,
    output cs_pkg::t_res o_res
);

    logic         r_valid;
    cs_pkg::t_res r_res;

    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

endmodule

/* rtl/cs_ctrl.sv */
// Sequencer with the histogram memory: load, drain walk and clearing pass.
module cs_ctrl #(
    parameter int VALUE_BITS = cs_pkg::VALUE_BITS_DEF,
    parameter int MAX_ITEMS  = cs_pkg::MAX_ITEMS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic [cs_pkg::IN_W-1:0] i_item_value,
    input  logic                    i_end_of_set,
    output logic                    o_busy,
    input  logic                    i_obuf_ready,
    output logic                    o_push,
    output cs_pkg::t_res            o_res
);

    localparam int NUM_BINS = 1 << VALUE_BITS;
    localparam int CNT_W    = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0]      CNT_MAX  = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0]      CNT_ONE  = CNT_W'(1);
    localparam logic [VALUE_BITS-1:0] ADDR_TOP = {VALUE_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0] ADDR_ONE = VALUE_BITS'(1);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_LD,
        S_RD,
        S_EVAL,
        S_EMIT
    } t_state;

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]      r_items, n_items;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_drop, n_drop;
    logic                  r_last, n_last;

    logic [CNT_W-1:0]      r_mem [NUM_BINS];
    logic [CNT_W-1:0]      r_rdata;

    logic [VALUE_BITS+cs_pkg::IN_W-1:0]  w_in_ext;
    logic [VALUE_BITS-1:0]               w_in_val;
    logic [VALUE_BITS+cs_pkg::OUT_W-1:0] w_out_ext;
    logic [VALUE_BITS-1:0]               w_rd_addr;
    logic                                w_we;
    logic [CNT_W-1:0]                    w_wd;

    // Shared count unit: bin increment on load, bin count decrement on emit.
    logic [CNT_W-1:0] w_alu_a, w_alu_b, w_alu_sum;
    logic             w_alu_dec;

    assign w_in_ext  = {{VALUE_BITS{1'b0}}, i_item_value};
    assign w_in_val  = w_in_ext[VALUE_BITS-1:0];
    assign w_out_ext = {{cs_pkg::OUT_W{1'b0}}, r_addr};

    assign w_rd_addr = (r_state == S_IDLE) ? w_in_val : r_addr;
    assign w_alu_sum = w_alu_dec ? (w_alu_a - CNT_ONE) : (w_alu_a + CNT_ONE);

    assign o_busy         = (r_state != S_IDLE);
    assign o_res.value    = w_out_ext[cs_pkg::OUT_W-1:0];
    assign o_res.last     = (r_items == CNT_ONE);
    assign o_res.overflow = r_drop;

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_items   = r_items;
        n_cnt     = r_cnt;
        n_drop    = r_drop;
        n_last    = r_last;
        w_we      = 1'b0;
        w_wd      = '0;
        o_push    = 1'b0;
        w_alu_a   = r_rdata;
        w_alu_b   = r_items;
        w_alu_dec = 1'b0;
        case (r_state)
            S_CLR: begin
                w_we   = 1'b1;
                n_addr = r_addr + ADDR_ONE;
                if (r_addr == ADDR_TOP) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (r_items < CNT_MAX) begin
                        n_addr  = w_in_val;
                        n_last  = i_end_of_set;
                        n_state = S_LD;
                    end else begin
                        n_drop = 1'b1;
                        if (i_end_of_set) begin
                            n_addr  = '0;
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_LD: begin
                // read-modify-write of the item's bin
                w_we    = 1'b1;
                w_wd    = w_alu_sum;
                n_items = w_alu_b + CNT_ONE;
                if (r_last) begin
                    n_addr  = '0;
                    n_state = S_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                // bin is cleared as it is read
                w_we = 1'b1;
                if (r_rdata == '0) begin
                    n_addr  = r_addr + ADDR_ONE;
                    n_state = S_RD;
                end else begin
                    n_cnt   = r_rdata;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                w_alu_a   = r_cnt;
                w_alu_dec = 1'b1;
                if (i_obuf_ready) begin
                    o_push  = 1'b1;
                    n_cnt   = w_alu_sum;
                    n_items = w_alu_b - CNT_ONE;
                    if (r_items == CNT_ONE) begin
                        n_drop  = 1'b0;
                        n_addr  = '0;
                        n_state = S_IDLE;
                    end else if (r_cnt == CNT_ONE) begin
                        n_addr  = r_addr + ADDR_ONE;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_addr  <= '0;
            r_items <= '0;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_items <= n_items;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_addr] <= w_wd;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

endmodule

/* test/cs_sort_checker.sv */
// Checker for the counting sort core: predicts each sorted run and compares the results.
`timescale 1ns / 100ps

module cs_sort_checker (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic [cs_pkg::IN_W-1:0]  i_item_value,
    input  logic                     i_end_of_set,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic [cs_pkg::OUT_W-1:0] i_sorted_value,
    input  logic                     i_end_of_run,
    input  logic                     i_overflow,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_sets_done,
    output int                       o_results_checked
);

    localparam int VALUE_BITS = cs_pkg::VALUE_BITS_DEF;
    localparam int MAX_ITEMS  = cs_pkg::MAX_ITEMS_DEF;
    localparam int NUM_BINS   = 1 << VALUE_BITS;
    localparam logic [cs_pkg::IN_W-1:0] VALUE_MASK =
        {cs_pkg::IN_W{1'b1}} >> (cs_pkg::IN_W - VALUE_BITS);
    localparam int REPORT_LIMIT = 10;

    logic [6:0]              bin_count [NUM_BINS];
    int                      held_items;
    logic [cs_pkg::IN_W-1:0] peak_value;
    logic                    set_dropped;

    cs_pkg::t_res expected_sorted[$];
    cs_pkg::t_res want;
    int           mismatches      = 0;
    int           sets_done       = 0;
    int           results_checked = 0;

    task automatic clear_histogram();
        for (int b = 0; b < NUM_BINS; b++) begin
            bin_count[b] = 7'd0;
        end
        held_items  = 0;
        peak_value  = '0;
        set_dropped = 1'b0;
    endtask

    // Count one request; on the end mark queue the whole ascending run.
    task automatic count_request(input logic [cs_pkg::IN_W-1:0] raw, input logic eos);
        logic [cs_pkg::IN_W-1:0] v;
        int                      total;
        int                      n;
        cs_pkg::t_res            r;
        v = raw & VALUE_MASK;
        if (held_items < MAX_ITEMS) begin
            bin_count[v] = bin_count[v] + 7'd1;
            held_items++;
            if (v > peak_value) begin
                peak_value = v;
            end
        end else begin
            set_dropped = 1'b1;
        end
        if (eos) begin
            total = 0;
            for (int b = 0; b <= int'(peak_value); b++) begin
                total += int'(bin_count[b]);
            end
            if (total > MAX_ITEMS) begin
                total = MAX_ITEMS;
            end
            n = 0;
            for (int b = 0; b <= int'(peak_value); b++) begin
                for (int k = 0; k < int'(bin_count[b]); k++) begin
                    if (n < total) begin
                        r.value    = b[cs_pkg::OUT_W-1:0];
                        r.last     = (n == total - 1);
                        r.overflow = set_dropped;
                        expected_sorted.push_back(r);
                        n++;
                    end
                end
            end
            clear_histogram();
            sets_done++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_histogram();
            expected_sorted.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_sorted.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("%0t: unexpected result value %0d last %0b overflow %0b",
                                 $time, i_sorted_value, i_end_of_run, i_overflow);
                    end
                    mismatches++;
                end else begin
                    want = expected_sorted.pop_front();
                    if (i_sorted_value !== want.value || i_end_of_run !== want.last ||
                        i_overflow !== want.overflow) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display("%0t: expected value %0d last %0b overflow %0b, got %0d %0b %0b",
                                     $time, want.value, want.last, want.overflow,
                                     i_sorted_value, i_end_of_run, i_overflow);
                        end
                        mismatches++;
                    end
                    results_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                count_request(i_item_value, i_end_of_set);
            end
        end
        o_pending         <= expected_sorted.size();
        o_fail_count      <= mismatches;
        o_sets_done       <= sets_done;
        o_results_checked <= results_checked;
    end

endmodule

/* test/tb_top.sv */
// Top of the counting sort testbench: clock, reset, request and stall stimulus, verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int IN_W           = cs_pkg::IN_W;
    localparam int MAX_ITEMS      = cs_pkg::MAX_ITEMS_DEF;
    localparam int RANDOM_ITEMS   = 440;
    localparam int HOLD_CYCLES    = 500;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int END_WAIT       = 600;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} t_stall_mode;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [cs_pkg::IN_W-1:0]  item_value;
    logic                     end_of_set;
    logic                     out_valid;
    logic                     out_stall;
    logic [cs_pkg::OUT_W-1:0] sorted_value;
    logic                     end_of_run;
    logic                     overflow;

    int fail_count;
    int pending;
    int sets_done;
    int results_checked;

    int burst_left    = 0;
    int items_sent    = 0;
    int overfull_sets = 0;
    int idle_cycles   = 0;
    bit pressure_go   = 1'b0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    counting_sort_core DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_item_value   (item_value),
        .i_end_of_set   (end_of_set),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_sorted_value (sorted_value),
        .o_end_of_run   (end_of_run),
        .o_overflow     (overflow)
    );

    cs_sort_checker sort_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_item_value      (item_value),
        .i_end_of_set      (end_of_set),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_sorted_value    (sorted_value),
        .i_end_of_run      (end_of_run),
        .i_overflow        (overflow),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_sets_done       (sets_done),
        .o_results_checked (results_checked)
    );

    // Offer one request; a new burst may open with an idle gap.
    task automatic send_item(input logic [cs_pkg::IN_W-1:0] v, input logic eos);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid   <= 1'b1;
        item_value <= v;
        end_of_set <= eos;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_set(input int len, input bit narrow);
        logic [cs_pkg::IN_W-1:0] v;
        if (len > MAX_ITEMS) begin
            overfull_sets++;
        end
        for (int i = 0; i < len; i++) begin
            v = narrow ? IN_W'($urandom_range(0, 15)) : IN_W'($urandom_range(0, 255));
            send_item(v, i == len - 1);
        end
    endtask

    // Receiver: random stall patterns, plus one long hold-off to back the core up.
    initial begin
        t_stall_mode mode;
        int          span;
        bit          held;
        held      = 1'b0;
        out_stall = 1'b0;
        forever begin
            if (pressure_go && !held) begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                held = 1'b1;
            end
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(10, 80);
            repeat (span) begin
                @(negedge clk);
                case (mode)
                    STALL_NONE:   out_stall <= 1'b0;
                    STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                    STALL_TOGGLE: out_stall <= ~out_stall;
                    default:      out_stall <= 1'b0;
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results pending",
                         idle_cycles, pending);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int pick;
        int set_len;
        int directed_items;
        bit narrow;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        item_value = '0;
        end_of_set = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single smallest and largest values, duplicates, wide spread, bit patterns
        send_item(8'd0, 1'b1);
        send_item(8'd255, 1'b1);
        send_item(8'd5, 1'b0);
        send_item(8'd5, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd5, 1'b1);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd128, 1'b0);
        send_item(8'd1, 1'b0);
        send_item(8'd254, 1'b0);
        send_item(8'd0, 1'b1);
        send_item(8'd170, 1'b0);
        send_item(8'd85, 1'b0);
        send_item(8'd3, 1'b0);
        send_item(8'd200, 1'b0);
        send_item(8'd3, 1'b1);
        send_item(8'd7, 1'b0);
        send_item(8'd7, 1'b0);
        send_item(8'd7, 1'b0);
        send_item(8'd7, 1'b1);
        directed_items = items_sent;

        // over-capacity set while the receiver holds off; end mark lands on a dropped request
        pressure_go = 1'b1;
        send_set(MAX_ITEMS + 6, 1'b0);
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                set_len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
            end else if (pick < 13) begin
                set_len = MAX_ITEMS;
            end else if (pick < 35) begin
                set_len = $urandom_range(13, MAX_ITEMS - 1);
            end else begin
                set_len = $urandom_range(1, 12);
            end
            narrow = ($urandom_range(0, 9) < 3);
            send_set(set_len, narrow);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (END_WAIT) @(posedge clk);

        $display("Sent %0d requests in %0d data sets, %0d of them over capacity",
                 items_sent, sets_done, overfull_sets);
        $display("Checked %0d sorted results; receiver held off once for %0d cycles",
                 results_checked, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/cs_pkg.sv
rtl/cs_obuf.sv
rtl/cs_ctrl.sv
rtl/counting_sort_core.sv
test/cs_sort_checker.sv
test/tb_top.sv
